### rtl/core/baif_pkg.sv
// ============================================================================
// baif_pkg - shared definitions for the baro/inertial altitude filter
// Widths, register indexes, sequencer step codes, state type and the
// rounding and saturation helpers used by the filter datapath.
// ============================================================================
package baif_pkg;

  // Number of recent acceleration samples kept for the stillness test.
  localparam int RING_DEPTH = 8;
  localparam int RING_IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // Field and datapath widths.
  localparam int DATA_W  = 32;
  localparam int DT_W    = 16;
  localparam int GAIN_W  = 24;
  localparam int THR_W   = 31;
  localparam int ERR_W   = 33;
  localparam int K_W     = 25;
  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = 64;
  localparam int SUM_W   = 48;

  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 64;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ALT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_VEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_THR = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_ALT_RESET  = 24'd65536;
  localparam logic [GAIN_W-1:0] GAIN_VEL_RESET  = 24'd65536;
  localparam logic [THR_W-1:0]  STILL_THR_RESET = 31'd6554;

  // Sequencer steps. A multiply issued at step n is consumed at step n+1.
  // The saturated results are registered at OP_SAT, so the last step comes
  // one after it and hands them to the output register.
  localparam int ARITH_LAST = 11;
  localparam int STEP_LAST_I = (RING_DEPTH > ARITH_LAST) ? RING_DEPTH : ARITH_LAST;
  localparam int STEP_W = $clog2(STEP_LAST_I + 1);
  localparam logic [STEP_W-1:0] STEP_LAST   = STEP_W'(STEP_LAST_I);
  localparam logic [STEP_W-1:0] SCAN_END    = STEP_W'(RING_DEPTH);
  localparam logic [STEP_W-1:0] OP_GV_DT    = STEP_W'(0);
  localparam logic [STEP_W-1:0] OP_ERR_GVLO = STEP_W'(1);
  localparam logic [STEP_W-1:0] OP_ERR_GVHI = STEP_W'(2);
  localparam logic [STEP_W-1:0] OP_ERR_KLO  = STEP_W'(3);
  localparam logic [STEP_W-1:0] OP_ERR_KHI  = STEP_W'(4);
  localparam logic [STEP_W-1:0] OP_VEA_DT   = STEP_W'(5);
  localparam logic [STEP_W-1:0] OP_ACC_DT   = STEP_W'(6);
  localparam logic [STEP_W-1:0] OP_PVKE_DT  = STEP_W'(7);
  localparam logic [STEP_W-1:0] OP_AD_DT    = STEP_W'(8);
  localparam logic [STEP_W-1:0] OP_ALT_ACC  = STEP_W'(9);
  localparam logic [STEP_W-1:0] OP_SAT      = STEP_W'(10);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } baif_state_t;

  // Control from the sequencer to the acceleration ring.
  typedef struct packed {
    logic                  wr;
    logic                  clr;
    logic                  scan;
    logic [RING_IDX_W-1:0] idx;
  } ring_ctrl_t;

  localparam logic signed [SUM_W-1:0] SAT_MAX = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN = {{(SUM_W-31){1'b1}}, {31{1'b0}}};

  // Round half up of x / 2^s.
  function automatic logic signed [SUM_W-1:0] rnd_shift(
    input logic signed [MUL_P_W-1:0] x,
    input int unsigned               s
  );
    logic signed [MUL_P_W-1:0] t;
    t = x + ($signed(MUL_P_W'(1)) <<< (s - 1));
    t = t >>> s;
    return t[SUM_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
    logic [DATA_W-1:0] r;
    if (x > SAT_MAX) begin
      r = SAT_MAX[DATA_W-1:0];
    end else if (x < SAT_MIN) begin
      r = SAT_MIN[DATA_W-1:0];
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/baif_mul.sv
// ============================================================================
// baif_mul - shared signed by unsigned multiplier
// Multiplies a signed operand by an unsigned step-size operand and
// registers the product for use in the following cycle.
// ============================================================================
module baif_mul import baif_pkg::*; (
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic        [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] p
);

  logic signed [MUL_A_W+MUL_B_W:0] full;

  assign full = a * $signed({1'b0, b});

  always_ff @(posedge clk) begin
    p <= full[MUL_P_W-1:0];
  end

endmodule

### rtl/core/baif_ring.sv
// ============================================================================
// baif_ring - ring of recent acceleration samples with stillness scan
// Stores each new sample at the next slot and, one entry per cycle,
// checks whether any stored magnitude exceeds the stillness threshold.
// ============================================================================
module baif_ring import baif_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  ring_ctrl_t               ctrl,
  input  logic signed [DATA_W-1:0] wr_data,
  input  logic        [THR_W-1:0]  threshold,
  output logic                     moving
);

  logic signed [DATA_W-1:0] ring [RING_DEPTH];
  logic [RING_IDX_W-1:0]    slot;
  logic [DATA_W-1:0]        sel;
  logic [DATA_W:0]          mag;
  logic                     over;

  assign sel  = ring[ctrl.idx];
  // True magnitude, so the most negative sample reads as 2^31.
  assign mag  = sel[DATA_W-1] ? (~{1'b1, sel} + (DATA_W+1)'(1)) : {1'b0, sel};
  assign over = mag > {2'b00, threshold};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring[i] <= '0;
      end
      slot   <= '0;
      moving <= 1'b0;
    end else begin
      if (ctrl.wr) begin
        ring[slot] <= wr_data;
        if (slot == RING_IDX_W'(RING_DEPTH - 1)) begin
          slot <= '0;
        end else begin
          slot <= slot + RING_IDX_W'(1);
        end
      end
      if (ctrl.clr) begin
        moving <= 1'b0;
      end else if (ctrl.scan && over) begin
        moving <= 1'b1;
      end
    end
  end

endmodule

### rtl/core/baro_inertial_altitude_filter_core.sv
// ============================================================================
// baro_inertial_altitude_filter_core - complementary altitude filter
// Blends barometric altitude with inertial prediction and applies a
// zero-velocity update when recent acceleration samples show no motion.
// ============================================================================
// Usage
//   Input words arrive on the s_ stream channel; each carries the barometric
//   altitude, the prior altitude and velocity, a vertical acceleration and
//   a time step. One result word with the new altitude and velocity leaves
//   on the m_ stream channel for every input word.
//   Gains and the stillness threshold are written through the cfg_ port
//   only while the block is idle, a rule for the user that the block does
//   not enforce; writes to an unused index are ignored. All products run
//   through one shared 48 x 16 bit multiplier under a step sequencer, at
//   most one per step, while the ring of recent accelerations is scanned
//   one entry per cycle in parallel. After the last step the result is
//   loaded into the output register once that is free; a new word is
//   taken only in the idle state after the previous one finishes, so
//   the sequencer never overlaps the steps of two successive words.
//   The finished result sits in an output register: s_tready returns while
//   it waits for the receiver. If the receiver still stalls when the next
//   result is done, the sequencer holds that result until the register is
//   free. Reset clears the ring, the slot pointer, the handshake state and
//   restores the register defaults.
// ============================================================================
module baro_inertial_altitude_filter_core import baif_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // Stream input.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // s_tdata fields from bit 0 up: baro_altitude[31:0], prior_altitude[31:0],
  // prior_velocity[31:0], vert_accel[31:0], time_step[15:0].
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // Stream output.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // m_tdata fields from bit 0 up: new_altitude[31:0], new_velocity[31:0].
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  baif_state_t state, state_next;
  logic [STEP_W-1:0] step;

  // Configuration registers.
  logic [GAIN_W-1:0] gain_altitude;
  logic [GAIN_W-1:0] gain_velocity;
  logic [THR_W-1:0]  still_threshold;

  // Captured operands of the word in progress.
  logic signed [ERR_W-1:0]  err;
  logic signed [DATA_W-1:0] prior_altitude;
  logic signed [DATA_W-1:0] prior_velocity;
  logic signed [DATA_W-1:0] vert_accel;
  logic        [DT_W-1:0]   time_step;

  // Intermediate results between multiplies.
  logic        [K_W-1:0]     k;
  logic signed [MUL_P_W-1:0] lo;
  logic signed [SUM_W-1:0]   vea;
  logic signed [SUM_W-1:0]   pvke;
  logic signed [SUM_W-1:0]   ad;
  logic signed [SUM_W-1:0]   vel_sum;
  logic signed [SUM_W-1:0]   alt_sum;
  logic        [DATA_W-1:0]  alt_sat;
  logic        [DATA_W-1:0]  vel_sat;

  // Output register.
  logic              out_valid;
  logic [DATA_W-1:0] new_altitude;
  logic [DATA_W-1:0] new_velocity;

  logic accept;
  logic finish;
  logic load_out;

  logic signed [MUL_A_W-1:0] mul_a;
  logic        [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  ring_ctrl_t ring_ctrl;
  logic       moving;

  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {new_velocity, new_altitude};

  // --------------------------------------------------------------------------
  // Sequencer state machine.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    finish     = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step == STEP_LAST) begin
          finish = 1'b1;
        end
      end
      ST_HOLD: begin
        finish = 1'b1;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // The result leaves once the output register is free or being emptied.
    load_out = finish && (!out_valid || m_tready);
    if (finish) begin
      state_next = load_out ? ST_IDLE : ST_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (state == ST_RUN && step != STEP_LAST) begin
      step <= step + STEP_W'(1);
    end else begin
      step <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_altitude   <= GAIN_ALT_RESET;
      gain_velocity   <= GAIN_VEL_RESET;
      still_threshold <= STILL_THR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_ALT:  gain_altitude   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_VEL:  gain_velocity   <= cfg_data[GAIN_W-1:0];
        REG_STILL_THR: still_threshold <= cfg_data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier and its operand selection. The gains are split into
  // a low 16-bit part and a high part so every product fits one pass.
  // --------------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step)
      OP_GV_DT: begin
        mul_a = {{(MUL_A_W-GAIN_W){1'b0}}, gain_velocity};
        mul_b = time_step;
      end
      OP_ERR_GVLO: begin
        mul_a = {{(MUL_A_W-ERR_W){err[ERR_W-1]}}, err};
        mul_b = gain_velocity[MUL_B_W-1:0];
      end
      OP_ERR_GVHI: begin
        mul_a = {{(MUL_A_W-ERR_W){err[ERR_W-1]}}, err};
        mul_b = {{(2*MUL_B_W-GAIN_W){1'b0}}, gain_velocity[GAIN_W-1:MUL_B_W]};
      end
      OP_ERR_KLO: begin
        mul_a = {{(MUL_A_W-ERR_W){err[ERR_W-1]}}, err};
        mul_b = k[MUL_B_W-1:0];
      end
      OP_ERR_KHI: begin
        mul_a = {{(MUL_A_W-ERR_W){err[ERR_W-1]}}, err};
        mul_b = {{(2*MUL_B_W-K_W){1'b0}}, k[K_W-1:MUL_B_W]};
      end
      OP_VEA_DT: begin
        mul_a = vea;
        mul_b = time_step;
      end
      OP_ACC_DT: begin
        mul_a = {{(MUL_A_W-DATA_W){vert_accel[DATA_W-1]}}, vert_accel};
        mul_b = time_step;
      end
      OP_PVKE_DT: begin
        mul_a = pvke;
        mul_b = time_step;
      end
      OP_AD_DT: begin
        mul_a = ad;
        mul_b = time_step;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  baif_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // --------------------------------------------------------------------------
  // Datapath: each step folds the product of the previous step into the
  // running terms.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      err            <= {s_tdata[31], s_tdata[31:0]} - {s_tdata[63], s_tdata[63:32]};
      prior_altitude <= s_tdata[63:32];
      prior_velocity <= s_tdata[95:64];
      vert_accel     <= s_tdata[127:96];
      time_step      <= s_tdata[143:128];
    end
    if (state == ST_RUN) begin
      case (step)
        OP_ERR_GVLO: begin
          // gv*dt/2 in Q7.16, truncated.
          k <= {1'b0, gain_altitude} + {2'b00, prod[39:17]};
        end
        OP_ERR_GVHI: begin
          lo <= prod;
        end
        OP_ERR_KLO: begin
          vea <= prod[SUM_W-1:0] + rnd_shift(lo, 16)
                 + {{(SUM_W-DATA_W){vert_accel[DATA_W-1]}}, vert_accel};
        end
        OP_ERR_KHI: begin
          lo <= prod;
        end
        OP_VEA_DT: begin
          pvke <= prod[SUM_W-1:0] + rnd_shift(lo, 16)
                  + {{(SUM_W-DATA_W){prior_velocity[DATA_W-1]}}, prior_velocity};
        end
        OP_ACC_DT: begin
          vel_sum <= {{(SUM_W-DATA_W){prior_velocity[DATA_W-1]}}, prior_velocity}
                     + rnd_shift(prod, 16);
        end
        OP_PVKE_DT: begin
          ad <= prod[SUM_W-1:0];
        end
        OP_AD_DT: begin
          alt_sum <= {{(SUM_W-DATA_W){prior_altitude[DATA_W-1]}}, prior_altitude}
                     + rnd_shift(prod, 16);
        end
        OP_ALT_ACC: begin
          // accel*dt^2/2 term.
          alt_sum <= alt_sum + rnd_shift(prod, 33);
        end
        OP_SAT: begin
          alt_sat <= sat32(alt_sum);
          vel_sat <= sat32(vel_sum);
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Acceleration ring. The new sample is written at the accepting edge, so
  // it takes part in the scan that follows over steps 0 to RING_DEPTH-1.
  // --------------------------------------------------------------------------
  always_comb begin
    ring_ctrl.wr   = accept;
    ring_ctrl.clr  = accept;
    ring_ctrl.scan = (state == ST_RUN) && (step < SCAN_END);
    ring_ctrl.idx  = step[RING_IDX_W-1:0];
  end

  baif_ring u_ring (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ring_ctrl),
    .wr_data   (s_tdata[127:96]),
    .threshold (still_threshold),
    .moving    (moving)
  );

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      new_altitude <= alt_sat;
      new_velocity <= moving ? vel_sat : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_RUN) && (step == '0))
    else $error("accepted word did not start the sequencer at step zero");

  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_RUN) |-> (step == '0))
    else $error("step counter moved outside of a run");

  a_hold_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) |-> out_valid)
    else $error("result held while the output register was free");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load_out |=> m_tvalid)
    else $error("loaded result not presented on the output");

endmodule

### tb/baro_inertial_altitude_filter_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// baro_inertial_altitude_filter_core_tb - self-checking altitude filter bench
// Streams altitude, velocity, acceleration and time step words into the filter
// while both sides idle in random bursts. A bit-exact fixed-point predictor,
// which keeps its own acceleration history and gain registers, computes the
// expected altitude and velocity of every accepted word. Each result word is
// checked against the oldest prediction. Several gain and threshold settings
// are used, the extremes among them, and each is written while the block is
// idle.
// ============================================================================
module baro_inertial_altitude_filter_core_tb;
  import baif_pkg::*;

  // Wide signed type for the predictor. The largest intermediate product is
  // just under 2^63, so 96 bits leave ample headroom.
  typedef logic signed [95:0] wide_t;

  // One input word. A packed struct lists its first member in the top bits,
  // so this order matches the s_tdata layout with baro_altitude at bit 0.
  typedef struct packed {
    logic [DT_W-1:0]          dt;
    logic signed [DATA_W-1:0] accel;
    logic signed [DATA_W-1:0] pvel;
    logic signed [DATA_W-1:0] palt;
    logic signed [DATA_W-1:0] baro;
  } sample_t;

  // One result word in m_tdata order: new_velocity above new_altitude.
  typedef struct packed {
    logic [DATA_W-1:0] vel;
    logic [DATA_W-1:0] alt;
  } filter_out_t;

  // Index 3 is not a register and must be ignored by the block.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  localparam wide_t Q_MAX = 2147483647;
  localparam wide_t Q_MIN = -Q_MAX - 1;

  // Idle time after the last result before any register write.
  localparam int SETTLE_CYCLES = 20;
  // Allows for roughly 1500 words at worst-case pacing, with a wide margin.
  localparam int CYCLE_LIMIT = 400000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  baro_inertial_altitude_filter_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the registers and the acceleration history.
  logic [GAIN_W-1:0]        ga_reg = GAIN_ALT_RESET;
  logic [GAIN_W-1:0]        gv_reg = GAIN_VEL_RESET;
  logic [THR_W-1:0]         thr_reg = STILL_THR_RESET;
  logic signed [DATA_W-1:0] accel_hist [RING_DEPTH];
  int                       hist_slot = 0;

  sample_t     pending_words[$];   // words not yet offered to the block
  filter_out_t expected_fix[$];    // predicted results, oldest first

  int  words_offered = 0;          // bumped by the sender at the falling edge
  int  words_taken = 0;            // bumped by the monitor at the rising edge
  int  send_gap = 0;
  int  hold_left = 0;
  int  idle_pct = 0;
  bit  quiet = 1'b0;               // no idling at all in the closing phase
  int  still_left = 0;
  bit  failed = 1'b0;
  int  cycle_cnt = 0;

  initial begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      accel_hist[i] = '0;
    end
  end

  // Round half up of x / 2^s: add half an LSB, then floor by arithmetic shift.
  function automatic wide_t round_half_up(input wide_t x, input int s);
    wide_t t;
    t = x + (wide_t'(1) <<< (s - 1));
    return t >>> s;
  endfunction

  function automatic logic [DATA_W-1:0] clamp_q16(input wide_t x);
    if (x > Q_MAX) begin
      return 32'h7FFF_FFFF;
    end else if (x < Q_MIN) begin
      return 32'h8000_0000;
    end else begin
      return x[DATA_W-1:0];
    end
  endfunction

  // Computes the result for one accepted word and advances the history.
  function automatic filter_out_t filter_predict(input sample_t w);
    wide_t       baro, palt, pvel, acc, dt, ga, gv, thr;
    wide_t       err, k, ke, step, aterm, ve, vel, mag;
    logic        moving;
    filter_out_t r;
    baro = w.baro;
    palt = w.palt;
    pvel = w.pvel;
    acc  = w.accel;
    dt   = w.dt;
    ga   = ga_reg;
    gv   = gv_reg;
    thr  = thr_reg;

    // Altitude: the blend gain grows by gv*dt/2, truncated, before it scales
    // the barometric error; acceleration adds accel*dt^2/2.
    err   = baro - palt;
    k     = ga + ((gv * dt) >>> 17);
    ke    = round_half_up(k * err, 16);
    step  = round_half_up(dt * (pvel + ke), 16);
    aterm = round_half_up(acc * dt * dt, 33);
    r.alt = clamp_q16(palt + step + aterm);

    ve  = round_half_up(gv * err, 16);
    vel = pvel + round_half_up(dt * (ve + acc), 16);

    // The current sample enters the history before the stillness test. The
    // magnitude is a true absolute value, so -2^31 counts as 2^31.
    accel_hist[hist_slot] = w.accel;
    hist_slot = (hist_slot == RING_DEPTH - 1) ? 0 : hist_slot + 1;
    moving = 1'b0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      mag = accel_hist[i];
      if (mag < 0) begin
        mag = -mag;
      end
      if (mag > thr) begin
        moving = 1'b1;
      end
    end
    r.vel = moving ? clamp_q16(vel) : '0;
    return r;
  endfunction

  function automatic sample_t make_sample(input int b, input int p, input int v,
                                          input int a, input int d);
    sample_t s;
    s.baro  = b;
    s.palt  = p;
    s.pvel  = v;
    s.accel = a;
    s.dt    = d[DT_W-1:0];
    return s;
  endfunction

  function automatic logic signed [DATA_W-1:0] edge_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh0;
      3: return -32'sh1;
      4: return 32'sh1;
      default: return $urandom();
    endcase
  endfunction

  // Acceleration within two LSBs of the threshold, either sign.
  function automatic logic signed [DATA_W-1:0] accel_near_thr();
    longint m;
    m = longint'(thr_reg) + int'($urandom_range(0, 4)) - 2;
    if (m < 0) begin
      m = 0;
    end
    if ($urandom_range(0, 1) == 1 && m <= 64'sd2147483648) begin
      return DATA_W'(-m);
    end else if (m > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else begin
      return DATA_W'(m);
    end
  endfunction

  // Random words. Most look like a real flight: altitude error small,
  // moderate velocity, typical time steps, and runs of quiet acceleration
  // long enough to flush the history. The rest is raw noise and extremes.
  function automatic sample_t rand_sample();
    sample_t s;
    longint  a;
    int      mode;
    mode = $urandom_range(0, 99);
    if (still_left == 0 && mode < 10) begin
      still_left = $urandom_range(RING_DEPTH, RING_DEPTH + 4);
    end
    if (still_left > 0 || mode < 45) begin
      s.palt = int'($urandom_range(0, 32'h3FFF_FFFF)) - (1 << 29);
      s.baro = s.palt + int'($urandom_range(0, 32'h000F_FFFF)) - (1 << 19);
      s.pvel = int'($urandom_range(0, 32'h007F_FFFF)) - (1 << 22);
      s.dt   = ($urandom_range(0, 3) == 0) ? DT_W'($urandom_range(0, 65535))
                                           : DT_W'($urandom_range(300, 3300));
      if (still_left > 0) begin
        still_left--;
        a = $urandom_range(0, thr_reg);
        s.accel = ($urandom_range(0, 1) == 1) ? DATA_W'(-a) : DATA_W'(a);
      end else if ($urandom_range(0, 1) == 1) begin
        s.accel = accel_near_thr();
      end else begin
        s.accel = int'($urandom_range(0, 32'h001F_FFFF)) - (1 << 20);
      end
    end else if (mode < 75) begin
      s.baro  = $urandom();
      s.palt  = $urandom();
      s.pvel  = $urandom();
      s.accel = $urandom();
      s.dt    = DT_W'($urandom_range(0, 65535));
    end else begin
      s.baro  = edge_value();
      s.palt  = edge_value();
      s.pvel  = edge_value();
      s.accel = edge_value();
      case ($urandom_range(0, 2))
        0: s.dt = '0;
        1: s.dt = '1;
        default: s.dt = DT_W'($urandom_range(0, 65535));
      endcase
    end
    return s;
  endfunction

  // Sender: a new word is presented once the previous one has been taken.
  // The gap after a word is drawn when the word is offered.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || words_taken == words_offered) begin
      if (send_gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_words.size() != 0) begin
        s_tdata       <= pending_words.pop_front();
        s_tvalid      <= 1'b1;
        words_offered <= words_offered + 1;
        if (!quiet && $urandom_range(1, 100) <= idle_pct) begin
          send_gap <= $urandom_range(1, 7);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: ready by default, with random stall bursts.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (!quiet && $urandom_range(1, 100) <= idle_pct) begin
        hold_left <= $urandom_range(1, 7);
      end
    end
  end

  // Monitor: predicts on every accepted input word and checks every
  // accepted result word against the oldest prediction.
  always @(posedge clk) begin
    filter_out_t want;
    filter_out_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_fix.push_back(filter_predict(sample_t'(s_tdata)));
        words_taken <= words_taken + 1;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_fix.size() == 0) begin
          $display("%0t: result word with nothing expected, got %h", $time, m_tdata);
          failed = 1'b1;
        end else begin
          want = expected_fix.pop_front();
          if (got.alt !== want.alt) begin
            $display("%0t: new_altitude expected %h, got %h", $time, want.alt, got.alt);
            failed = 1'b1;
          end
          if (got.vel !== want.vel) begin
            $display("%0t: new_velocity expected %h, got %h", $time, want.vel, got.vel);
            failed = 1'b1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("baro_inertial_altitude_filter_core_tb: FAIL");
      $finish;
    end
  end

  // Waits until every word has been taken and every result checked, then
  // lets the block settle before anything else happens.
  task automatic wait_drained();
    while (pending_words.size() != 0 || words_taken != words_offered ||
           expected_fix.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; the predictor copy is updated the same way the block
  // masks its registers, and an unused index changes nothing.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_GAIN_ALT:  ga_reg  = val[GAIN_W-1:0];
      REG_GAIN_VEL:  gv_reg  = val[GAIN_W-1:0];
      REG_STILL_THR: thr_reg = val[THR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      quiet = (ph == 7);
      case (ph)
        0: idle_pct = 25;
        1: idle_pct = 40;
        2: idle_pct = 0;
        3: idle_pct = 70;
        4: idle_pct = 30;
        5: idle_pct = 15;
        6: idle_pct = 50;
        default: idle_pct = 0;
      endcase

      case (ph)
        0: begin
          // Reset settings. Full-scale words saturate both ways, and the
          // most negative acceleration counts as a magnitude of 2^31.
          pending_words.push_back(make_sample(0, 0, 0, 0, 0));
          pending_words.push_back(make_sample(32'h7FFF_FFFF, 32'h8000_0000,
                                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 65535));
          pending_words.push_back(make_sample(32'h8000_0000, 32'h7FFF_FFFF,
                                              32'h8000_0000, 32'h8000_0000, 65535));
          // A zero time step leaves altitude and velocity unchanged.
          pending_words.push_back(make_sample(12345678, -5000000, 3000000, 100000, 0));
          // Samples exactly at the threshold are not motion; once they have
          // replaced every entry the velocity is forced to zero.
          for (int i = 0; i < RING_DEPTH + 1; i++) begin
            pending_words.push_back(make_sample(1000000 + i * 4096, 990000, 20000,
                                                (i % 2 == 1) ? -6554 : 6554,
                                                655 + i * 100));
          end
          // One LSB above the threshold is motion, and the current sample
          // counts at once.
          pending_words.push_back(make_sample(2000000, 1900000, 5000, 6555, 1311));
          pending_words.push_back(make_sample(2000000, 2100000, -5000, -6555, 1311));
          pending_words.push_back(make_sample(-65536, 65536, -65536, 0, 65535));
        end
        1: begin
          write_reg(REG_GAIN_ALT, '0);
          write_reg(REG_GAIN_VEL, '0);
          write_reg(REG_STILL_THR, '0);
          write_reg(REG_NONE, CFG_DATA_W'($urandom()));
        end
        2: begin
          // Top bits above the gain width are dropped by the register.
          write_reg(REG_GAIN_ALT, '1);
          write_reg(REG_GAIN_VEL, 31'h00FF_FFFF);
          write_reg(REG_STILL_THR, '1);
          // With the largest threshold only -2^31 means motion.
          for (int i = 0; i < 3; i++) begin
            pending_words.push_back(make_sample(500000, 400000, 70000,
                                                32'h7FFF_FFFF, 3000));
          end
          pending_words.push_back(make_sample(500000, 600000, 70000,
                                              32'h8000_0000, 3000));
          for (int i = 0; i < RING_DEPTH; i++) begin
            pending_words.push_back(make_sample(500000, 450000, -70000,
                                                -32'sh7FFF_FFFF, 3000));
          end
        end
        3: begin
          write_reg(REG_GAIN_ALT, 31'(GAIN_ALT_RESET));
          write_reg(REG_GAIN_VEL, 31'(GAIN_VEL_RESET));
          write_reg(REG_STILL_THR, 31'(STILL_THR_RESET));
        end
        4: begin
          write_reg(REG_GAIN_ALT, CFG_DATA_W'($urandom_range(32'h8000, 32'h3_0000)));
          write_reg(REG_GAIN_VEL, CFG_DATA_W'($urandom_range(32'h4000, 32'h2_0000)));
          write_reg(REG_STILL_THR, CFG_DATA_W'($urandom_range(32'h2000, 32'h2_0000)));
        end
        5: begin
          write_reg(REG_NONE, CFG_DATA_W'($urandom()));
          write_reg(REG_GAIN_ALT, CFG_DATA_W'($urandom()));
          write_reg(REG_GAIN_VEL, CFG_DATA_W'($urandom()));
          write_reg(REG_STILL_THR, CFG_DATA_W'($urandom()));
        end
        6: begin
          write_reg(REG_GAIN_ALT, '0);
          write_reg(REG_GAIN_VEL, 31'h00FF_FFFF);
          write_reg(REG_STILL_THR, CFG_DATA_W'($urandom_range(0, 32'h0010_0000)));
        end
        default: begin
          // Closing phase: a typical tuning, gain near the square root of two.
          write_reg(REG_GAIN_ALT, 31'h0001_6A0A);
          write_reg(REG_GAIN_VEL, 31'h0001_0000);
          write_reg(REG_STILL_THR, 31'(STILL_THR_RESET));
        end
      endcase

      if (ph != 0) begin
        for (int n = 0; n < 210; n++) begin
          pending_words.push_back(rand_sample());
        end
      end
    end

    wait_drained();
    if (!failed) begin
      $display("baro_inertial_altitude_filter_core_tb: PASS");
    end else begin
      $display("baro_inertial_altitude_filter_core_tb: FAIL");
    end
    $finish;
  end

endmodule
